/* rtl/bgs_pkg.sv */
`timescale 1ns / 1ps

package bgs_pkg;

  localparam int GAIN_STEPS = 8;
  localparam int GAIN_W     = 3;
  localparam int FRAME_BITS = 16;
  localparam int CNT_W      = 4;
  localparam int CMD_W      = 8;
  localparam int LOCK_W     = 16;
  localparam int PIN_COUNT  = 4;

  localparam logic [CMD_W-1:0] CMD_WRITE = 8'h40;

  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_REFRESH = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  button_level;
  } in_t;

  typedef struct packed {
    logic                 mosi_bit;
    logic                 frame_last;
    logic [GAIN_W-1:0]    gain_code_out;
    logic [PIN_COUNT-1:0] led_enable;
    logic [PIN_COUNT-1:0] led_level;
  } out_t;

  // Charlieplex pin pairs, one per gain code.
  localparam logic [1:0] LED_LOW_PIN  [GAIN_STEPS] = '{2'd1, 2'd2, 2'd0, 2'd0,
                                                      2'd1, 2'd2, 2'd3, 2'd1};
  localparam logic [1:0] LED_HIGH_PIN [GAIN_STEPS] = '{2'd2, 2'd1, 2'd1, 2'd2,
                                                      2'd0, 2'd0, 2'd1, 2'd3};

endpackage

/* rtl/button_gain_stepper_spi_pga.sv */
`timescale 1ns / 1ps

// Button-driven gain stepper with a serial write frame and charlieplex LED drive.
//
// Input channel (in_valid/in_ready/in_data): one button sample or refresh per transfer.
// A falling button edge outside the lockout window steps the gain code (wrapping to 0)
// and queues a 16-bit frame: command byte 0x40 then the gain code, MSB first.
// A refresh queues the same frame for the current gain and changes nothing.
// Output channel (out_valid/out_ready/out_data): one frame bit per transfer, frame_last
// on the sixteenth bit, plus the gain code and LED pin enables/levels on every bit.
// Config channel (cfg_valid/cfg_data): lockout length in samples; always ready.
//
// A frame item is held in the input register, then loads the serializer.
// Throughput: items that make no frame are taken one per cycle while no frame item waits
// in the input register. A frame holds the serializer for its sixteen bits, one bit a
// cycle when out_ready stays high; a second frame item waits in the input register.
// Receiver stall: the current bit holds until out_ready; the input register fills
// and in_ready drops once a frame item cannot enter the serializer.
// Reset: gain code 0, button released, lockout cleared, no frame in flight.
module button_gain_stepper_spi_pga import bgs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LOCK_W-1:0] cfg_data
);

  // Input register
  logic              s1_valid;
  in_t               s1_item;

  // Block state
  logic              prev_level;
  logic [GAIN_W-1:0] gain_index;
  logic [LOCK_W-1:0] lockout_left;
  logic [LOCK_W-1:0] lockout_ticks;

  // Serializer
  logic              busy;
  logic [CNT_W-1:0]  bit_cnt;
  logic [GAIN_W-1:0] frame_gain;

  logic              is_refresh;
  logic              locked;
  logic              press;
  logic              s1_frame;
  logic [GAIN_W-1:0] gain_next;
  logic [GAIN_W-1:0] gain_sel;
  logic              ser_done;
  logic              ser_free;
  logic              s1_adv;
  logic [FRAME_BITS-1:0] frame_word;

  // Decode the held item against the current state.
  assign is_refresh = (s1_item.kind == KIND_REFRESH);
  assign locked     = (lockout_left != '0);
  assign press      = !is_refresh && !locked && prev_level && !s1_item.button_level;
  assign s1_frame   = is_refresh || press;
  assign gain_next  = (gain_index >= GAIN_W'(GAIN_STEPS - 1)) ? '0 : gain_index + 1'b1;
  assign gain_sel   = press ? gain_next : gain_index;

  // The serializer can take a new frame when idle or on its final bit transfer.
  assign ser_done = busy && out_ready && (bit_cnt == CNT_W'(FRAME_BITS - 1));
  assign ser_free = !busy || ser_done;
  assign s1_adv   = s1_valid && (!s1_frame || ser_free);
  assign in_ready = !s1_valid || s1_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ticks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      lockout_ticks <= cfg_data;
    end
  end

  // Input register: refill on every transfer, drain when the item retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // Update gain, edge tracking and lockout as the item retires; refresh leaves all alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level   <= 1'b1;
      gain_index   <= '0;
      lockout_left <= '0;
    end else if (s1_adv && !is_refresh) begin
      if (locked) begin
        lockout_left <= lockout_left - 1'b1;
      end else if (press) begin
        gain_index   <= gain_next;
        prev_level   <= 1'b0;
        lockout_left <= lockout_ticks;
      end else begin
        prev_level <= s1_item.button_level;
      end
    end
  end

  // Serializer: load a frame, then advance one bit per output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (s1_adv && s1_frame) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (ser_done) begin
      busy <= 1'b0;
    end else if (busy && out_ready) begin
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_frame) begin
      frame_gain <= gain_sel;
    end
  end

  // Frame layout: command byte, zero pad, gain code in the low bits.
  assign frame_word = {CMD_WRITE, {(FRAME_BITS - CMD_W - GAIN_W){1'b0}}, frame_gain};

  assign out_valid              = busy;
  assign out_data.mosi_bit      = frame_word[CNT_W'(FRAME_BITS - 1) - bit_cnt];
  assign out_data.frame_last    = (bit_cnt == CNT_W'(FRAME_BITS - 1));
  assign out_data.gain_code_out = frame_gain;
  assign out_data.led_enable    = (PIN_COUNT'(1) << LED_LOW_PIN[frame_gain]) |
                                  (PIN_COUNT'(1) << LED_HIGH_PIN[frame_gain]);
  assign out_data.led_level     = PIN_COUNT'(1) << LED_HIGH_PIN[frame_gain];

endmodule

/* rtl/bgs_checker.sv */
`timescale 1ns / 1ps

module bgs_checker import bgs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled bit holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output bit changed while stalled");

  // A frame keeps going after a non-final bit and keeps its gain code.
  a_frame_gain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.frame_last |=>
      out_valid && (out_data.gain_code_out == $past(out_data.gain_code_out)))
    else $error("frame broken or gain changed mid-frame");

  // LED drive: one high pin, two enabled pins, high pin among the enabled.
  a_led: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_data.led_level) && ($countones(out_data.led_enable) == 2)
      && ((out_data.led_level & ~out_data.led_enable) == '0))
    else $error("bad charlieplex drive");

  // Reset leaves no frame in flight and the input open.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("frame or stall survived reset");

endmodule

bind button_gain_stepper_spi_pga bgs_checker u_bgs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* dv/button_gain_stepper_spi_pga_tb.sv */
`timescale 1ns / 1ps

module button_gain_stepper_spi_pga_tb;
  import bgs_pkg::*;

  // Run length guard: far above the slowest legal run, in which every item
  // sends a full frame under random receiver stalls and one long hold-off.
  localparam int CYCLE_LIMIT = 100000;
  // Long receiver hold-off, enough for a frame in flight plus a queued one.
  localparam int HOLD_CYCLES = 400;
  // Idle wait before a lockout write, so the input register has drained.
  localparam int SETTLE      = 8;

  // Charlieplex pin pairs per gain code: the sink pin and the driven-high pin.
  localparam logic [1:0] SINK_PIN  [GAIN_STEPS] = '{2'd1, 2'd2, 2'd0, 2'd0,
                                                   2'd1, 2'd2, 2'd3, 2'd1};
  localparam logic [1:0] DRIVE_PIN [GAIN_STEPS] = '{2'd2, 2'd1, 2'd1, 2'd2,
                                                   2'd0, 2'd0, 2'd1, 2'd3};

  // Directed script: one row per input transfer or lockout write. Rows with
  // typed set carry the frame word and LED drive read straight off the spec;
  // the rest are checked against the gain predictor.
  typedef enum logic {
    ROW_SEND    = 1'b0,
    ROW_LOCKOUT = 1'b1
  } row_op_t;

  typedef struct packed {
    row_op_t              op;
    kind_t                kind;
    logic                 lvl;
    logic [LOCK_W-1:0]    ticks;
    logic                 typed;
    logic [15:0]          word;
    logic [PIN_COUNT-1:0] en;
    logic [PIN_COUNT-1:0] lv;
  } row_t;

  localparam int SCRIPT_LEN = 27;
  localparam row_t SCRIPT [SCRIPT_LEN] = '{
    // refresh straight out of reset: gain 0, no step
    '{ROW_SEND,    KIND_REFRESH, 1'b1, 16'd0, 1'b1, 16'h4000, 4'b0110, 4'b0100},
    // first press from the released reset level: gain 1
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b1, 16'h4001, 4'b0110, 4'b0010},
    // button held low: no new edge
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    // refresh with the level bit low must still ignore the level
    '{ROW_SEND,    KIND_REFRESH, 1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    // top gain code
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b1, 16'h4007, 4'b1010, 4'b1000},
    '{ROW_SEND,    KIND_SAMPLE,  1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    // wrap from the top code back to 0
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b1, 16'h4000, 4'b0110, 4'b0100},
    // lockout of two samples
    '{ROW_LOCKOUT, KIND_SAMPLE,  1'b0, 16'd2, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    // refresh inside the lockout: frame, no countdown
    '{ROW_SEND,    KIND_REFRESH, 1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    // two samples swallowed by the lockout, the second a would-be press
    '{ROW_SEND,    KIND_SAMPLE,  1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    // lockout over, level was never updated, so low is no edge
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b1, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0},
    '{ROW_SEND,    KIND_SAMPLE,  1'b0, 16'd0, 1'b0, 16'h0,    4'h0,    4'h0}
  };

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LOCK_W-1:0] cfg_data  = '0;

  // Gain predictor state, mirrored from the block's architectural state.
  logic              prev_lvl   = 1'b1;
  logic [GAIN_W-1:0] gain_idx   = '0;
  logic [LOCK_W-1:0] lock_left  = '0;
  logic [LOCK_W-1:0] lock_ticks = '0;

  // Frame bits still owed by the block, oldest first.
  out_t frame_bits_due [$];

  // Shared stimulus controls: steady turns off idling on both sides;
  // each bump of hold_req asks the receiver for one long hold-off.
  logic steady   = 1'b0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  logic next_lvl = 1'b1;
  int   cycles = 0;
  int   errors = 0;
  int   bits_checked = 0;
  int   taken = 0;
  int   dropped = 0;
  int   presses = 0;
  int   refreshes = 0;

  button_gain_stepper_spi_pga dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Advance the predictor by one accepted item. Return FRAME_BITS when a
  // frame is due, 0 when the sample only updates the level, and -1 when the
  // lockout swallows it.
  function automatic int step_gain(input in_t item);
    if (item.kind == KIND_REFRESH) return FRAME_BITS;
    if (lock_left != '0) begin
      lock_left = lock_left - 1'b1;
      return -1;
    end
    if (prev_lvl && !item.button_level) begin
      gain_idx  = (gain_idx == GAIN_W'(GAIN_STEPS - 1)) ? '0 : gain_idx + 1'b1;
      prev_lvl  = 1'b0;
      lock_left = lock_ticks;
      return FRAME_BITS;
    end
    prev_lvl = item.button_level;
    return 0;
  endfunction

  // Queue the sixteen serial bits of one write frame, MSB first.
  function automatic void push_frame(input logic [15:0] word,
                                     input logic [PIN_COUNT-1:0] en,
                                     input logic [PIN_COUNT-1:0] lv);
    out_t bit_due;
    for (int k = 0; k < FRAME_BITS; k++) begin
      bit_due.mosi_bit      = word[15-k];
      bit_due.frame_last    = (k == FRAME_BITS - 1);
      bit_due.gain_code_out = word[GAIN_W-1:0];
      bit_due.led_enable    = en;
      bit_due.led_level     = lv;
      frame_bits_due.push_back(bit_due);
    end
  endfunction

  // Random item: mostly clean release/press runs, some refreshes, some noise.
  function automatic in_t pick_item();
    in_t item;
    int  roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      item.kind         = KIND_REFRESH;
      item.button_level = 1'($urandom_range(0, 1));
    end else if (roll < 27) begin
      item.kind         = KIND_SAMPLE;
      item.button_level = 1'($urandom_range(0, 1));
    end else begin
      item.kind         = KIND_SAMPLE;
      item.button_level = next_lvl;
      if ($urandom_range(0, 99) < 60) next_lvl = ~next_lvl;
    end
    return item;
  endfunction

  // Drop valid for a random number of cycles, unless in a steady stretch.
  task automatic gap();
    if (!steady) begin
      while ($urandom_range(0, 99) < 21) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      if ($urandom_range(0, 99) < 3) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(2, 20)) @(posedge clk);
      end
    end
  endtask

  // Offer one item, hold it until the transfer, then predict what it owes.
  // A typed row supplies its own frame; the predictor still tracks state.
  task automatic feed(input in_t item,
                      input logic typed = 1'b0,
                      input logic [15:0] word = '0,
                      input logic [PIN_COUNT-1:0] en = '0,
                      input logic [PIN_COUNT-1:0] lv = '0);
    int owed;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed = step_gain(item);
    if (owed < 0) dropped++;
    else taken++;
    if (item.kind == KIND_REFRESH) refreshes++;
    else if (owed == FRAME_BITS) presses++;
    if (owed == FRAME_BITS) begin
      if (typed) begin
        push_frame(word, en, lv);
      end else begin
        push_frame({CMD_WRITE, 5'd0, gain_idx},
                   (4'b0001 << SINK_PIN[gain_idx]) | (4'b0001 << DRIVE_PIN[gain_idx]),
                   4'b0001 << DRIVE_PIN[gain_idx]);
      end
    end
  endtask

  // Stop offering and wait for every owed frame bit, then idle for the SETTLE wait
  // so that a sample with no frame has surely left the input register.
  task automatic drain_frames();
    in_valid <= 1'b0;
    while (frame_bits_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_lockout(input logic [LOCK_W-1:0] ticks);
    drain_frames();
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    lock_ticks = ticks;
  endtask

  // Receiver: random stalls, none during a steady stretch, and a long
  // hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 21);
    end
  end

  // Compare every output transfer against the oldest owed frame bit.
  always @(posedge clk) begin : check_bits
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_bits_due.size() == 0) begin
        $error("unexpected frame bit transfer: %b", out_data);
        errors++;
      end else begin
        want = frame_bits_due.pop_front();
        bits_checked++;
        if (out_data.mosi_bit != want.mosi_bit) begin
          $error("mosi_bit: expected %0d, got %0d", want.mosi_bit, out_data.mosi_bit);
          errors++;
        end
        if (out_data.frame_last != want.frame_last) begin
          $error("frame_last: expected %0d, got %0d", want.frame_last, out_data.frame_last);
          errors++;
        end
        if (out_data.gain_code_out != want.gain_code_out) begin
          $error("gain_code_out: expected %0d, got %0d",
                 want.gain_code_out, out_data.gain_code_out);
          errors++;
        end
        if (out_data.led_enable != want.led_enable) begin
          $error("led_enable: expected %b, got %b", want.led_enable, out_data.led_enable);
          errors++;
        end
        if (out_data.led_level != want.led_level) begin
          $error("led_level: expected %b, got %b", want.led_level, out_data.led_level);
          errors++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d frame bits still owed",
             cycles, frame_bits_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_t item;
    int  mid_ticks;
    int  press_mark;

    // Hold reset, then release it once for good.
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: walk the script.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].op == ROW_LOCKOUT) begin
        set_lockout(SCRIPT[i].ticks);
      end else begin
        gap();
        item.kind         = SCRIPT[i].kind;
        item.button_level = SCRIPT[i].lvl;
        feed(item, SCRIPT[i].typed, SCRIPT[i].word, SCRIPT[i].en, SCRIPT[i].lv);
      end
    end

    // Random part: four lockout settings, 36 offered items each.
    // Phase 0 pauses the sender mid-way until all frames drain; phase 1
    // issues a long receiver hold-off while items keep coming; phase 3
    // runs with no idling at all.
    mid_ticks = $urandom_range(2, 6);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_lockout(16'd1);
        1: set_lockout(16'd3);
        2: set_lockout(LOCK_W'(mid_ticks));
        default: set_lockout(16'd0);
      endcase
      steady <= (p == 3);
      for (int n = 0; n < 36; n++) begin
        gap();
        feed(pick_item());
        if (p == 0 && n == 18) drain_frames();
        if (p == 1 && n == 8) hold_req <= hold_req + 1;
      end
    end

    // Back to no lockout for a short random tail.
    set_lockout(16'd0);
    steady <= 1'b0;
    for (int n = 0; n < 20; n++) begin
      gap();
      feed(pick_item());
    end

    // Top lockout: press with the full 65535 window loaded, then offer a
    // few samples, which the window swallows, and refreshes, which still
    // send their frame.
    set_lockout(16'hFFFF);
    steady     <= 1'b1;
    press_mark = presses;
    while (presses == press_mark) begin
      item.kind         = KIND_SAMPLE;
      item.button_level = (lock_left != '0) ? 1'($urandom_range(0, 1)) : ~prev_lvl;
      feed(item);
    end
    for (int k = 0; k < 12; k++) begin
      item.kind         = (k % 4 == 3) ? KIND_REFRESH : KIND_SAMPLE;
      item.button_level = 1'($urandom_range(0, 1));
      feed(item);
    end

    // Let the last frame drain, then watch for stray transfers.
    in_valid <= 1'b0;
    while (frame_bits_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d transfers (%0d presses, %0d refreshes), %0d samples held off,",
             taken, presses, refreshes, dropped);
    $display("%0d frame bits checked over lockouts 0, 2, 1, 3, %0d and a press into 65535.",
             bits_checked, mid_ticks);
    if (errors == 0 && frame_bits_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bgs_pkg.sv
rtl/button_gain_stepper_spi_pga.sv
rtl/bgs_checker.sv
dv/button_gain_stepper_spi_pga_tb.sv
